FILE: rtl/cia_pkg.sv
// ----------------------------------------------------------------------------
// Complex integer ALU package
// Operation codes, queue entry types and sizes shared by the ALU modules.
// ----------------------------------------------------------------------------
package cia_pkg;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_MAG = 3'd4
	} op_t;

	// Classified operation carried from the front to the back.
	typedef enum logic [1:0] {
		K_NONE,
		K_ADDSUB,
		K_MUL,
		K_DIVMAG
	} kind_t;

	typedef struct packed {
		logic [2:0]  cmd;
		kind_t       kind;
		logic [31:0] a_re;
		logic [31:0] a_im;
		logic [31:0] b_re;
		logic [31:0] b_im;
	} item_t;

	typedef struct packed {
		logic [31:0] res_re;
		logic [31:0] res_im;
		logic        div_zero;
	} result_t;

	localparam int QDepth = 4;
	localparam int QAw = $clog2(QDepth);

endpackage

FILE: rtl/cia_fifo.sv
// ----------------------------------------------------------------------------
// Complex integer ALU item queue
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module cia_fifo import cia_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t wdata,
	output logic  full,
	input  logic  pop,
	output item_t rdata,
	output logic  empty
);

	item_t            mem_q [QDepth];
	logic [QAw-1:0]   wp_q, rp_q;
	logic [QAw:0]     cnt_q;
	logic             do_push, do_pop;

	assign full    = cnt_q == (QAw+1)'(QDepth);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wp_q <= wp_q + 1'b1;
			if (do_pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QAw+1)'(do_push) - (QAw+1)'(do_pop);
		end
	end

endmodule

FILE: rtl/cia_front.sv
// ----------------------------------------------------------------------------
// Complex integer ALU front end
// Accepts items, decodes the operation code and pushes them into the queue.
// ----------------------------------------------------------------------------
module cia_front import cia_pkg::*; (
	input  logic        push,
	output logic        full,
	input  logic [2:0]  cmd,
	input  logic [31:0] a_re,
	input  logic [31:0] a_im,
	input  logic [31:0] b_re,
	input  logic [31:0] b_im,
	output logic        q_push,
	output item_t       q_item,
	input  logic        q_full
);

	kind_t kind;

	always_comb begin
		case (cmd)
			OP_ADD, OP_SUB: kind = K_ADDSUB;
			OP_MUL:         kind = K_MUL;
			OP_DIV, OP_MAG: kind = K_DIVMAG;
			default:        kind = K_NONE;
		endcase
	end

	assign full   = q_full;
	assign q_push = push;
	assign q_item = '{cmd: cmd, kind: kind, a_re: a_re, a_im: a_im, b_re: b_re, b_im: b_im};

endmodule

FILE: rtl/cia_back.sv
// ----------------------------------------------------------------------------
// Complex integer ALU back end
// Pipelined datapath: products, then sums, then a 32-step divide and root
// pipeline that every item passes through so that order is kept.
// ----------------------------------------------------------------------------
module cia_back import cia_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  item_t   in_item,
	output logic    in_ready,
	output logic    out_valid,
	output result_t out_res,
	input  logic    out_ready
);

	localparam int Steps = 32;  // restoring divide / root steps

	// Stage 1: products.
	logic        v_s1;
	item_t       it_s1;
	logic [63:0] p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1, p_bb_s1, p_cc_s1;
	// Stage 2: sums, setup of the iterative stages.
	logic        v_s2;
	logic [2:0]  cmd_s2;
	logic [31:0] re_s2, im_s2, nr_s2, ni_s2, den_s2;
	logic [63:0] sq_s2;
	logic        nr_neg_s2, ni_neg_s2;

	// Iteration pipeline: entry 0 is the setup, each later entry is one step of both divides and the root.
	logic        v_p   [Steps+1];
	logic [2:0]  cmd_p [Steps+1];
	logic [31:0] re_p  [Steps+1];
	logic [31:0] im_p  [Steps+1];
	logic [31:0] d_p   [Steps+1];
	logic [31:0] qr_p  [Steps+1];  // dividend shifting into quotient
	logic [31:0] rr_p  [Steps+1];
	logic [31:0] qi_p  [Steps+1];
	logic [31:0] ri_p  [Steps+1];
	logic        sr_p  [Steps+1];
	logic        si_p  [Steps+1];
	logic [63:0] x_p   [Steps+1];  // radicand, two bits consumed per step
	logic [31:0] rt_p  [Steps+1];
	logic [32:0] rm_p  [Steps+1];

	logic        v_o_q;
	result_t     res_o_q;
	logic        adv;

	// The whole pipeline moves together; it holds when the output is stalled.
	assign adv      = !v_o_q || out_ready;
	assign in_ready = adv;
	assign out_valid = v_o_q;
	assign out_res   = res_o_q;

	function automatic logic [31:0] mag32(input logic [31:0] v);
		mag32 = v[31] ? (32'd0 - v) : v;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_o_q <= 1'b0;
			for (int k = 0; k <= Steps; k++) v_p[k] <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_p[0] <= v_s2;
			for (int k = 1; k <= Steps; k++) v_p[k] <= v_p[k-1];
			v_o_q <= v_p[Steps];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			it_s1   <= in_item;
			p_rr_s1 <= in_item.a_re * in_item.b_re;
			p_ii_s1 <= in_item.a_im * in_item.b_im;
			p_ri_s1 <= in_item.a_re * in_item.b_im;
			p_ir_s1 <= in_item.a_im * in_item.b_re;
			if (in_item.kind == K_DIVMAG && in_item.cmd == OP_MAG) begin
				p_bb_s1 <= mag32(in_item.a_re) * mag32(in_item.a_re);
				p_cc_s1 <= mag32(in_item.a_im) * mag32(in_item.a_im);
			end else begin
				p_bb_s1 <= in_item.b_re * in_item.b_re;
				p_cc_s1 <= in_item.b_im * in_item.b_im;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s2 <= it_s1.cmd;
			case (it_s1.cmd)
				OP_ADD: begin
					re_s2 <= it_s1.a_re + it_s1.b_re;
					im_s2 <= it_s1.a_im + it_s1.b_im;
				end
				OP_SUB: begin
					re_s2 <= it_s1.a_re - it_s1.b_re;
					im_s2 <= it_s1.a_im - it_s1.b_im;
				end
				OP_MUL: begin
					re_s2 <= p_rr_s1[31:0] - p_ii_s1[31:0];
					im_s2 <= p_ri_s1[31:0] + p_ir_s1[31:0];
				end
				default: begin
					re_s2 <= '0;
					im_s2 <= '0;
				end
			endcase
			nr_s2  <= p_rr_s1[31:0] + p_ii_s1[31:0];
			ni_s2  <= p_ir_s1[31:0] - p_ri_s1[31:0];
			den_s2 <= p_bb_s1[31:0] + p_cc_s1[31:0];
			sq_s2  <= p_bb_s1 + p_cc_s1;
		end
	end

	// Signs of the quotients, and entry into the iteration pipeline.
	assign nr_neg_s2 = nr_s2[31] ^ den_s2[31];
	assign ni_neg_s2 = ni_s2[31] ^ den_s2[31];

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_p[0] <= cmd_s2;
			re_p[0]  <= re_s2;
			im_p[0]  <= im_s2;
			d_p[0]   <= mag32(den_s2);
			qr_p[0]  <= mag32(nr_s2);
			qi_p[0]  <= mag32(ni_s2);
			rr_p[0]  <= '0;
			ri_p[0]  <= '0;
			sr_p[0]  <= nr_neg_s2;
			si_p[0]  <= ni_neg_s2;
			x_p[0]   <= sq_s2;
			rt_p[0]  <= '0;
			rm_p[0]  <= '0;
		end
	end

	// The root remainder never exceeds twice the partial root, so it fits in
	// 33 bits; the shifted remainder and the trial value need 35.
	for (genvar g = 1; g <= Steps; g++) begin : g_step
		logic [32:0] tr, ti;
		logic [34:0] tm, trial;
		assign tr    = {rr_p[g-1], qr_p[g-1][31]};
		assign ti    = {ri_p[g-1], qi_p[g-1][31]};
		assign tm    = {rm_p[g-1], x_p[g-1][63:62]};
		assign trial = {1'b0, rt_p[g-1], 2'b01};
		always_ff @(posedge clk) begin
			if (adv) begin
				cmd_p[g] <= cmd_p[g-1];
				re_p[g]  <= re_p[g-1];
				im_p[g]  <= im_p[g-1];
				d_p[g]   <= d_p[g-1];
				sr_p[g]  <= sr_p[g-1];
				si_p[g]  <= si_p[g-1];
				x_p[g]   <= {x_p[g-1][61:0], 2'b00};
				if (tr >= {1'b0, d_p[g-1]}) begin
					rr_p[g] <= 32'(tr - {1'b0, d_p[g-1]});
					qr_p[g] <= {qr_p[g-1][30:0], 1'b1};
				end else begin
					rr_p[g] <= tr[31:0];
					qr_p[g] <= {qr_p[g-1][30:0], 1'b0};
				end
				if (ti >= {1'b0, d_p[g-1]}) begin
					ri_p[g] <= 32'(ti - {1'b0, d_p[g-1]});
					qi_p[g] <= {qi_p[g-1][30:0], 1'b1};
				end else begin
					ri_p[g] <= ti[31:0];
					qi_p[g] <= {qi_p[g-1][30:0], 1'b0};
				end
				if (tm >= trial) begin
					rm_p[g] <= 33'(tm - trial);
					rt_p[g] <= {rt_p[g-1][30:0], 1'b1};
				end else begin
					rm_p[g] <= tm[32:0];
					rt_p[g] <= {rt_p[g-1][30:0], 1'b0};
				end
			end
		end
	end

	// The root of a 64-bit value fits in 32 bits; values above the signed
	// maximum saturate.
	always_ff @(posedge clk) begin
		if (adv) begin
			case (cmd_p[Steps])
				OP_DIV: begin
					if (d_p[Steps] == '0) begin
						res_o_q <= '{res_re: '0, res_im: '0, div_zero: 1'b1};
					end else begin
						res_o_q.res_re <= sr_p[Steps] ? 32'd0 - qr_p[Steps] : qr_p[Steps];
						res_o_q.res_im <= si_p[Steps] ? 32'd0 - qi_p[Steps] : qi_p[Steps];
						res_o_q.div_zero <= 1'b0;
					end
				end
				OP_MAG: begin
					res_o_q.res_re   <= rt_p[Steps][31] ? 32'h7fff_ffff : rt_p[Steps];
					res_o_q.res_im   <= '0;
					res_o_q.div_zero <= 1'b0;
				end
				default: begin
					res_o_q <= '{res_re: re_p[Steps], res_im: im_p[Steps], div_zero: 1'b0};
				end
			endcase
		end
	end

endmodule

FILE: rtl/complex_integer_alu.sv
// ----------------------------------------------------------------------------
// Complex integer ALU
// Add, subtract, multiply, divide and magnitude on 32-bit Gaussian integers.
// ----------------------------------------------------------------------------
// channel  | ports                          | handshake
// input    | cmd a_re a_im b_re b_im        | push / full
// result   | res_re res_im div_zero         | pop / empty
//
// One item is accepted per cycle while full is low. Every item travels the
// same back-end pipeline of 36 registers (product, sum and setup stages, 32
// divide/root steps, one output register), so order is kept. An unpopped
// result holds the whole back end; the four-entry queue then fills and full
// rises.
// Reset empties the queue and pipeline.
// ----------------------------------------------------------------------------
module complex_integer_alu import cia_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [2:0]  cmd,
	input  logic signed [31:0] a_re,
	input  logic signed [31:0] a_im,
	input  logic signed [31:0] b_re,
	input  logic signed [31:0] b_im,
	input  logic        pop,
	output logic        empty,
	output logic signed [31:0] res_re,
	output logic signed [31:0] res_im,
	output logic        div_zero
);

	logic    q_push, q_full, q_empty, q_pop, out_valid;
	item_t   q_in, q_out;
	result_t res;

	cia_front u_front (
		.push(push), .full(full), .cmd(cmd), .a_re(a_re), .a_im(a_im),
		.b_re(b_re), .b_im(b_im), .q_push(q_push), .q_item(q_in), .q_full(q_full)
	);

	cia_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(q_push), .wdata(q_in), .full(q_full),
		.pop(q_pop), .rdata(q_out), .empty(q_empty)
	);

	logic b_ready;
	assign q_pop = b_ready && !q_empty;

	cia_back u_back (
		.clk(clk), .arst_n(arst_n), .in_valid(!q_empty), .in_item(q_out),
		.in_ready(b_ready), .out_valid(out_valid), .out_res(res), .out_ready(pop)
	);

	assign empty    = !out_valid;
	assign res_re   = res.res_re;
	assign res_im   = res.res_im;
	assign div_zero = res.div_zero;

	a_zero_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && div_zero) |-> (res_re == 0 && res_im == 0))
		else $error("div_zero with nonzero result");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(res_re) && $stable(res_im)))
		else $error("stalled result changed");

	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(full && !q_pop) |-> !q_empty)
		else $error("queue full yet empty");

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex integer ALU testbench
// Drives directed and random operand items through the push/full side and
// checks every popped result against an in-bench model of the arithmetic.
// ----------------------------------------------------------------------------
module tb;
	import cia_pkg::*;

	localparam int LATENCY = 40;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int N_RANDOM = 500;

	typedef struct {
		logic [2:0]  cmd;
		logic [31:0] ar;
		logic [31:0] ai;
		logic [31:0] br;
		logic [31:0] bi;
	} operands_t;

	typedef struct {
		logic [31:0] re;
		logic [31:0] im;
		logic        dz;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic [2:0] cmd = '0;
	logic signed [31:0] a_re = '0, a_im = '0, b_re = '0, b_im = '0;
	logic full, empty, div_zero;
	logic signed [31:0] res_re, res_im;

	operands_t pending_ops[$];
	answer_t answers_due[$];
	int mismatches = 0;
	int checked = 0;
	int accepted = 0;
	int idle_cycles = 0;
	bit calm = 1'b0;
	bit stim_done = 1'b0;
	int op_seen[8];

	complex_integer_alu i_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .cmd(cmd),
		.a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im), .pop(pop),
		.empty(empty), .res_re(res_re), .res_im(res_im), .div_zero(div_zero)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [31:0] mag32(logic [31:0] v);
		return v[31] ? -v : v;
	endfunction

	function automatic logic [31:0] trunc_div(logic [31:0] n, logic [31:0] d);
		logic [31:0] q;
		q = mag32(n) / mag32(d);
		return (n[31] ^ d[31]) ? -q : q;
	endfunction

	function automatic logic [63:0] floor_root(logic [63:0] x);
		logic [63:0] root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > x) bitv >>= 2;
		while (bitv != 0) begin
			if (x >= root + bitv) begin
				x -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	function automatic answer_t alu_answer(operands_t o);
		answer_t r;
		logic [31:0] nr, ni, den;
		logic [63:0] ma, mi, root;
		r = '{re: 0, im: 0, dz: 0};
		case (o.cmd)
			OP_ADD: begin
				r.re = o.ar + o.br;
				r.im = o.ai + o.bi;
			end
			OP_SUB: begin
				r.re = o.ar - o.br;
				r.im = o.ai - o.bi;
			end
			OP_MUL: begin
				r.re = o.ar * o.br - o.ai * o.bi;
				r.im = o.ar * o.bi + o.ai * o.br;
			end
			OP_DIV: begin
				nr = o.ar * o.br + o.ai * o.bi;
				ni = o.ai * o.br - o.ar * o.bi;
				den = o.br * o.br + o.bi * o.bi;
				if (den == 0) begin
					r.dz = 1'b1;
				end else begin
					r.re = trunc_div(nr, den);
					r.im = trunc_div(ni, den);
				end
			end
			OP_MAG: begin
				ma = {32'd0, mag32(o.ar)};
				mi = {32'd0, mag32(o.ai)};
				root = floor_root(ma * ma + mi * mi);
				r.re = (root > 64'd2147483647) ? 32'h7fffffff : root[31:0];
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] rand_part();
		case ($urandom_range(0, 5))
			0: return 32'h80000000;
			1: return 32'h7fffffff;
			2: return $urandom_range(0, 6) - 3;
			3: return $urandom_range(0, 131071) - 65536;
			default: return $urandom;
		endcase
	endfunction

	task automatic add_item(logic [2:0] c, logic [31:0] ar, logic [31:0] ai,
			logic [31:0] br, logic [31:0] bi);
		operands_t o;
		o = '{cmd: c, ar: ar, ai: ai, br: br, bi: bi};
		pending_ops.push_back(o);
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		mismatches++;
		$display("mismatch on %s at result %0d: got %h, expected %h", what, checked, got,
			want);
	endtask

	// Driver: the item on the ports leaves at an edge with push high and full low.
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				answers_due.push_back(alu_answer('{cmd: cmd, ar: a_re, ai: a_im, br: b_re,
					bi: b_im}));
				accepted++;
				op_seen[cmd]++;
			end
			if (!push || !full) begin
				if (pending_ops.size() > 0 && (calm || $urandom_range(0, 99) >= 23)) begin
					operands_t o;
					o = pending_ops.pop_front();
					push <= 1'b1;
					cmd <= o.cmd;
					a_re <= o.ar;
					a_im <= o.ai;
					b_re <= o.br;
					b_im <= o.bi;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each popped result against the oldest expected answer.
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				if (answers_due.size() == 0) begin
					report_mismatch("unexpected result", res_re, 32'd0);
				end else begin
					answer_t w;
					w = answers_due.pop_front();
					if (res_re !== w.re) report_mismatch("res_re", res_re, w.re);
					if (res_im !== w.im) report_mismatch("res_im", res_im, w.im);
					if (div_zero !== w.dz) begin
						report_mismatch("div_zero", 32'(div_zero), 32'(w.dz));
					end
				end
				checked++;
			end
			pop <= calm || ($urandom_range(0, 99) >= 23);
		end
	end

	// Watchdog on cycles with no accepted item on either side.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog expired with %0d results outstanding",
					answers_due.size());
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		int c;
		// Extremes, each operation, zero denominator, quotient overflow,
		// magnitude saturation and unused codes.
		add_item(OP_ADD, 32'h7fffffff, 32'h80000000, 32'h1, 32'hffffffff);
		add_item(OP_SUB, 32'h80000000, 32'h7fffffff, 32'h1, 32'hffffffff);
		add_item(OP_MUL, 32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff);
		add_item(OP_MUL, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
		add_item(OP_DIV, 32'd7, 32'd5, 32'd0, 32'd0);
		add_item(OP_DIV, 32'd7, 32'd5, 32'h00010000, 32'd0);
		add_item(OP_DIV, 32'd7, 32'd5, 32'h00010000, 32'h00010000);
		add_item(OP_DIV, 32'd100, -32'd37, 32'd3, -32'd4);
		add_item(OP_DIV, -32'd100, 32'd37, -32'd3, 32'd4);
		// Denominator of one, against a numerator of the most negative.
		add_item(OP_DIV, 32'h80000000, 32'd0, 32'd1, 32'd0);
		add_item(OP_DIV, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
		add_item(OP_MAG, 32'h80000000, 32'h80000000, 32'h12345678, 32'h9abcdef0);
		add_item(OP_MAG, 32'h7fffffff, 32'd0, 32'd0, 32'd0);
		add_item(OP_MAG, 32'd3, -32'd4, 32'd0, 32'd0);
		add_item(OP_MAG, 32'd0, 32'd0, 32'hffffffff, 32'hffffffff);
		add_item(OP_MAG, 32'h0000ffff, 32'h80000000, 32'd0, 32'd0);
		add_item(3'd5, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
		add_item(3'd6, 32'd1, 32'd2, 32'd3, 32'd4);
		add_item(3'd7, 32'h80000000, 32'h7fffffff, 32'd0, 32'd0);
		add_item(OP_ADD, 32'd0, 32'd0, 32'd0, 32'd0);
		for (int i = 0; i < N_RANDOM; i++) begin
			// Mostly the five defined operations, some unused codes.
			c = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
			add_item(c[2:0], rand_part(), rand_part(), rand_part(), rand_part());
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		// A stretch in the middle runs with no idling on either side.
		wait (accepted >= 200);
		calm = 1'b1;
		wait (accepted >= 300);
		calm = 1'b0;
		wait (pending_ops.size() == 0 && !push);
		wait (answers_due.size() == 0);
		repeat (LATENCY) @(posedge clk);
		$display("%0d items accepted, %0d results checked; per operation 0..7:", accepted,
			checked);
		$display("  %0d %0d %0d %0d %0d %0d %0d %0d", op_seen[0], op_seen[1], op_seen[2],
			op_seen[3], op_seen[4], op_seen[5], op_seen[6], op_seen[7]);
		if (mismatches == 0 && answers_due.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
